FILE: rtl/msb_first_bit_reader_unstuffing_defines.svh
// Assertion macros used by the checker file.
`ifndef MSB_FIRST_BIT_READER_UNSTUFFING_DEFINES_SVH
`define MSB_FIRST_BIT_READER_UNSTUFFING_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbr_pkg;

  localparam int unsigned MaxRead = 32;
  localparam logic [7:0]  ByteFf  = 8'hFF;
  localparam logic [7:0]  ByteZero = 8'h00;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_SHORT   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] byte_in;
    logic [5:0] bit_count;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  bits_read;
    logic [1:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/mbr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mbr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] byte_in;
  logic [5:0] bit_count;

  modport source (output valid, cmd, byte_in, bit_count, input ready);
  modport sink   (input valid, cmd, byte_in, bit_count, output ready);
endinterface

interface mbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [5:0]  bits_read;
  logic [1:0]  status;

  modport source (output valid, value, bits_read, status, input ready);
  modport sink   (input valid, value, bits_read, status, output ready);
endinterface

interface mbr_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/mbr_buffer.sv
`timescale 1ns / 1ps
`default_nettype none

module mbr_buffer #(
  parameter int unsigned BUFFER_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         discard_i,
  input  mbr_pkg::cmd_t cmd_i,
  output mbr_pkg::rsp_t rsp_o
);

  localparam int unsigned HW = $clog2(BUFFER_BITS + 1);

  logic [BUFFER_BITS-1:0] buf_q, buf_d;
  logic [HW-1:0]          held_q, held_d;
  logic                   ff_q, ff_d;

  logic [5:0]             cnt;
  logic [31:0]            top_bits;
  logic [BUFFER_BITS-1:0] ins;
  logic                   drop, full, short;

  assign cnt      = (cmd_i.bit_count > 6'(mbr_pkg::MaxRead)) ? 6'(mbr_pkg::MaxRead)
                                                             : cmd_i.bit_count;
  assign top_bits = buf_q[BUFFER_BITS-1 -: 32];
  assign ins      = {cmd_i.byte_in, {(BUFFER_BITS-8){1'b0}}} >> held_q;
  assign drop     = discard_i && ff_q && (cmd_i.byte_in == mbr_pkg::ByteZero);
  assign full     = ({1'b0, held_q} + (HW+1)'(8)) > (HW+1)'(BUFFER_BITS);
  assign short    = HW'(cnt) > held_q;

  always_comb begin
    buf_d  = buf_q;
    held_d = held_q;
    ff_d   = ff_q;
    rsp_o  = '0;
    unique case (mbr_pkg::cmd_e'(cmd_i.cmd))
      mbr_pkg::CMD_PUSH: begin
        priority if (drop) begin
          ff_d         = 1'b0;
          rsp_o.status = mbr_pkg::ST_DROPPED;
        end else if (full) begin
          rsp_o.status = mbr_pkg::ST_FULL;
        end else begin
          buf_d        = buf_q | ins;
          held_d       = held_q + HW'(8);
          ff_d         = (cmd_i.byte_in == mbr_pkg::ByteFf);
          rsp_o.status = mbr_pkg::ST_OK;
        end
      end
      mbr_pkg::CMD_READ: begin
        if (short) begin
          rsp_o.status = mbr_pkg::ST_SHORT;
        end else begin
          rsp_o.value     = top_bits >> (6'(mbr_pkg::MaxRead) - cnt);
          rsp_o.bits_read = cnt;
          rsp_o.status    = mbr_pkg::ST_OK;
          buf_d           = buf_q << cnt;
          held_d          = held_q - HW'(cnt);
        end
      end
      mbr_pkg::CMD_FLUSH: begin
        buf_d  = '0;
        held_d = '0;
        ff_d   = 1'b0;
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
      ff_q   <= 1'b0;
    end else if (en_i) begin
      buf_q  <= buf_d;
      held_q <= held_d;
      ff_q   <= ff_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/msb_first_bit_reader_unstuffing.sv
// MSB-first bit reader with JPEG byte unstuffing. Takes one command word per
// cycle when the output is not stalled (push byte, read 0..32 bits, flush) and
// returns one result word per command, in order. A command is registered on
// accept, executed against the bit buffer once the output register is free
// and its result registered there. The rate is set by the buffer update
// (insert or barrel shift), combinational between the two registers.
// Output stalls back-pressure the input only after the input register fills.
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bit_reader_unstuffing #(
  parameter int unsigned BUFFER_BITS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbr_cmd_if.sink   cmd_i,
  mbr_rsp_if.source rsp_o,
  mbr_cfg_if.sink   cfg_i
);

  mbr_pkg::cmd_t in_q;
  mbr_pkg::rsp_t rsp_q, rsp_d;
  logic          in_valid_q, in_valid_d;
  logic          out_valid_q, out_valid_d;
  logic          discard_q;
  logic          adv, in_fire;

  assign adv     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_fire = cmd_i.valid && cmd_i.ready;

  assign cmd_i.ready = !in_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  mbr_buffer #(
    .BUFFER_BITS (BUFFER_BITS)
  ) u_buffer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .discard_i (discard_q),
    .cmd_i     (in_q),
    .rsp_o     (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      discard_q   <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        discard_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= '{cmd: cmd_i.cmd, byte_in: cmd_i.byte_in, bit_count: cmd_i.bit_count};
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.value     = rsp_q.value;
  assign rsp_o.bits_read = rsp_q.bits_read;
  assign rsp_o.status    = rsp_q.status;

endmodule

`default_nettype wire

FILE: rtl/mbr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "msb_first_bit_reader_unstuffing_defines.svh"

module mbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] value_i,
  input logic [5:0]  bits_read_i,
  input logic [1:0]  status_i
);

  `MBR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result word dropped")
  `MBR_ASSERT_NOW(a_read_max, out_valid_i, bits_read_i <= 6'd32, "bits_read above 32")
  `MBR_ASSERT_NOW(a_err_zero, out_valid_i && (status_i != mbr_pkg::ST_OK),
                  (value_i == 32'd0) && (bits_read_i == 6'd0), "non-ok status with data")
  `MBR_ASSERT_NOW(a_empty_read, out_valid_i && (bits_read_i == 6'd0), value_i == 32'd0,
                  "value without bits")

endmodule

bind msb_first_bit_reader_unstuffing mbr_checker u_mbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .value_i     (rsp_o.value),
  .bits_read_i (rsp_o.bits_read),
  .status_i    (rsp_o.status)
);

`default_nettype wire

FILE: sim/tb_msb_first_bit_reader_unstuffing.sv
`timescale 1ns / 1ps

module tb_msb_first_bit_reader_unstuffing;

  localparam int unsigned QueueBits = 64;
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned RandPerPhase = 217;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    mbr_pkg::cmd_t word;
    bit            typed;
    logic [1:0]    want_status;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mbr_cmd_if cmd_if ();
  mbr_rsp_if rsp_if ();
  mbr_cfg_if cfg_if ();

  msb_first_bit_reader_unstuffing #(
    .BUFFER_BITS(QueueBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  always #4 clk_i = ~clk_i;

  // bit queue shadow: bits right-aligned, oldest at index held-1
  bit [63:0] bq_bits;
  int unsigned bq_held;
  bit bq_last_ff;
  bit unstuff_en;

  mbr_pkg::rsp_t rsp_q[$];
  row_t dir_rows[$];
  bit calm;
  int n_err, n_words, n_cfg;
  int n_push, n_read, n_flush, n_unused, n_drop, n_full, n_short;

  function automatic mbr_pkg::rsp_t predict_word(mbr_pkg::cmd_t w);
    mbr_pkg::rsp_t r;
    int unsigned n;
    bit [63:0] mask;
    r = '0;
    case (w.cmd)
      mbr_pkg::CMD_PUSH: begin
        if (unstuff_en && bq_last_ff && w.byte_in == mbr_pkg::ByteZero) begin
          bq_last_ff = 1'b0;
          r.status = mbr_pkg::ST_DROPPED;
        end else if (bq_held + 8 > QueueBits) begin
          r.status = mbr_pkg::ST_FULL;
        end else begin
          bq_bits = (bq_bits << 8) | 64'(w.byte_in);
          bq_held += 8;
          bq_last_ff = (w.byte_in == mbr_pkg::ByteFf);
          r.status = mbr_pkg::ST_OK;
        end
      end
      mbr_pkg::CMD_READ: begin
        n = (w.bit_count > mbr_pkg::MaxRead) ? mbr_pkg::MaxRead : w.bit_count;
        if (n > bq_held) begin
          r.status = mbr_pkg::ST_SHORT;
        end else begin
          mask = (64'd1 << n) - 64'd1;
          r.value = 32'((bq_bits >> (bq_held - n)) & mask);
          r.bits_read = 6'(n);
          r.status = mbr_pkg::ST_OK;
          bq_held -= n;
        end
      end
      mbr_pkg::CMD_FLUSH: begin
        bq_held = 0;
        bq_last_ff = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_err < 40)
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_err++;
  endtask

  task automatic check_word();
    mbr_pkg::rsp_t want;
    if (rsp_q.size() == 0) begin
      report_mismatch("word with nothing pending", rsp_if.value, 32'd0);
    end else begin
      want = rsp_q.pop_front();
      if (rsp_if.value !== want.value)
        report_mismatch("value", rsp_if.value, want.value);
      if (rsp_if.bits_read !== want.bits_read)
        report_mismatch("bits_read", 32'(rsp_if.bits_read), 32'(want.bits_read));
      if (rsp_if.status !== want.status)
        report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
    end
  endtask

  // call at a clock edge; returns at the edge the word is taken
  task automatic send_word(mbr_pkg::cmd_t w, bit typed, logic [1:0] want_status);
    mbr_pkg::rsp_t pred;
    mbr_pkg::rsp_t typed_rsp;
    while (!calm && $urandom_range(0, 99) < 19) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= w.cmd;
    cmd_if.byte_in <= w.byte_in;
    cmd_if.bit_count <= w.bit_count;
    do @(posedge clk_i); while (!cmd_if.ready);
    pred = predict_word(w);
    typed_rsp = '0;
    typed_rsp.status = want_status;
    rsp_q.push_back(typed ? typed_rsp : pred);
    n_words++;
    case (w.cmd)
      mbr_pkg::CMD_PUSH:  n_push++;
      mbr_pkg::CMD_READ:  n_read++;
      mbr_pkg::CMD_FLUSH: n_flush++;
      default:            n_unused++;
    endcase
    case (pred.status)
      mbr_pkg::ST_DROPPED: n_drop++;
      mbr_pkg::ST_SHORT:   n_short++;
      mbr_pkg::ST_FULL:    n_full++;
      default: ;
    endcase
  endtask

  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    unstuff_en = v;
    cfg_if.valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic add_row(row_kind_e k, logic [1:0] c, logic [7:0] b, logic [5:0] n,
                         bit typed, logic [1:0] st);
    row_t r;
    r.kind = k;
    r.word.cmd = c;
    r.word.byte_in = b;
    r.word.bit_count = n;
    r.typed = typed;
    r.want_status = st;
    dir_rows.push_back(r);
  endtask

  // result side
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_word();
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 19);
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    mbr_pkg::cmd_t w;
    int unsigned k, lim, cnt;
    logic [7:0] b;

    cmd_if.valid <= 1'b0;
    cmd_if.cmd <= mbr_pkg::CMD_PUSH;
    cmd_if.byte_in <= 8'd0;
    cmd_if.bit_count <= 6'd0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= 1'b0;
    bq_bits = '0;
    bq_held = 0;
    bq_last_ff = 1'b0;
    unstuff_en = 1'b0;
    calm = 1'b0;

    // directed: empty queue, unused command, stuffing, full queue, oversized read
    add_row(ROW_CFG,  mbr_pkg::CMD_PUSH,  8'h01, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'h00, 6'd0,  1, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'hFF, 6'd1,  1, mbr_pkg::ST_SHORT);
    add_row(ROW_WORD, CmdUnused,          8'hFF, 6'd63, 1, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'hFF, 6'd0,  1, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h00, 6'd0,  1, mbr_pkg::ST_DROPPED);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h00, 6'd63, 1, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h12, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'hA5, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h5A, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h80, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h01, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'hFF, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h7F, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h00, 6'd0,  1, mbr_pkg::ST_DROPPED);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h55, 6'd0,  1, mbr_pkg::ST_FULL);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'h00, 6'd63, 0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'h00, 6'd32, 0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'h00, 6'd1,  1, mbr_pkg::ST_SHORT);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'hFF, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h00, 6'd0,  1, mbr_pkg::ST_DROPPED);
    add_row(ROW_CFG,  mbr_pkg::CMD_PUSH,  8'h00, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'hFF, 6'd0,  0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_PUSH,  8'h00, 6'd0,  1, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'h00, 6'd19, 0, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_FLUSH, 8'hFF, 6'd63, 1, mbr_pkg::ST_OK);
    add_row(ROW_WORD, mbr_pkg::CMD_READ,  8'h00, 6'd1,  1, mbr_pkg::ST_SHORT);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_cfg(dir_rows[i].word.byte_in[0]);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want_status);
      end
    end

    // random: unstuffing on, off, on; each change waits for the pipe to drain
    for (int p = 0; p < 3; p++) begin
      settle();
      write_cfg(p != 1);
      cnt = 0;
      while (cnt < RandPerPhase) begin
        calm = (p == 1 && cnt >= 60 && cnt < 180);
        w.byte_in = 8'($urandom_range(0, 255));
        w.bit_count = 6'($urandom_range(0, 63));
        k = $urandom_range(0, 99);
        if (k < 45) begin
          k = $urandom_range(0, 9);
          b = (k < 2) ? mbr_pkg::ByteFf : (k == 2) ? mbr_pkg::ByteZero
                                                   : 8'($urandom_range(0, 255));
          w.cmd = mbr_pkg::CMD_PUSH;
          w.byte_in = b;
          send_word(w, 0, mbr_pkg::ST_OK);
          cnt++;
        end else if (k < 55) begin
          w.cmd = mbr_pkg::CMD_PUSH;
          w.byte_in = mbr_pkg::ByteFf;
          send_word(w, 0, mbr_pkg::ST_OK);
          w.byte_in = mbr_pkg::ByteZero;
          send_word(w, 0, mbr_pkg::ST_OK);
          cnt += 2;
        end else if (k < 90) begin
          w.cmd = mbr_pkg::CMD_READ;
          k = $urandom_range(0, 9);
          lim = (bq_held < mbr_pkg::MaxRead) ? bq_held : mbr_pkg::MaxRead;
          if (k < 6) w.bit_count = 6'($urandom_range(0, lim));
          else if (k < 9) w.bit_count = 6'($urandom_range(0, mbr_pkg::MaxRead));
          send_word(w, 0, mbr_pkg::ST_OK);
          cnt++;
        end else if (k < 95) begin
          w.cmd = mbr_pkg::CMD_FLUSH;
          send_word(w, 0, mbr_pkg::ST_OK);
          cnt++;
        end else begin
          w.cmd = CmdUnused;
          send_word(w, 0, mbr_pkg::ST_OK);
          cnt++;
        end
      end
      calm = 1'b0;
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words (%0d push, %0d read, %0d flush, %0d unused), %0d config writes",
             n_words, n_push, n_read, n_flush, n_unused, n_cfg);
    $display("Seen %0d stuffed zeros dropped, %0d full-queue refusals, %0d short reads",
             n_drop, n_full, n_short);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mbr_pkg.sv
rtl/mbr_if.sv
rtl/mbr_buffer.sv
rtl/msb_first_bit_reader_unstuffing.sv
rtl/mbr_checker.sv
sim/tb_msb_first_bit_reader_unstuffing.sv
